// File: hw/rtl/spg_pkg.sv
// Shared types and constants of the sine plasma pixel generator.
`timescale 1ns / 1ps
`default_nettype none

package spg_pkg;

  localparam int unsigned SQRT_STEPS = 16;
  localparam int unsigned TURN_K = 166886;
  localparam int unsigned PHASE_STEP = 205;
  localparam int unsigned SCALE_628 = 25723;
  localparam int unsigned PHASE_G = 8561;
  localparam int unsigned PHASE_B = 17121;
  localparam int unsigned RECIP_10 = 838861;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned V_OFFSET = 65536;
  localparam int unsigned CH_OFFSET = 2097152;
  localparam int unsigned ANGLE_W = 25;
  localparam int unsigned CH_ANGLE_W = 16;

  typedef struct packed {
    logic [8:0] pixel_x;
    logic [7:0] pixel_y;
  } pixel_in_t;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic [16:0] pixel_address;
  } pixel_out_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] a0;
    logic [ANGLE_W-1:0] a1;
    logic [ANGLE_W-1:0] a2;
    logic [23:0]        t;
  } side_t;

endpackage

`default_nettype wire

// File: hw/rtl/spg_sqrt_cell.sv
// One restoring square root step, registered, with the angle sideband.
`timescale 1ns / 1ps
`default_nettype none

module spg_sqrt_cell #(
  parameter int unsigned INDEX = 0
) (
  input  wire logic           clk,
  input  wire logic [31:0]    rem_in,
  input  wire logic [31:0]    root_in,
  input  wire spg_pkg::side_t side_in,
  output logic [31:0]         rem_out,
  output logic [31:0]         root_out,
  output spg_pkg::side_t      side_out
);

  localparam logic [31:0] BIT = 32'(1) << (30 - 2 * INDEX);

  logic [32:0] trial;

  assign trial = {1'b0, root_in} + {1'b0, BIT};

  always_ff @(posedge clk) begin
    side_out <= side_in;
    if ({1'b0, rem_in} >= trial) begin
      rem_out  <= rem_in - trial[31:0];
      root_out <= (root_in >> 1) + BIT;
    end else begin
      rem_out  <= rem_in;
      root_out <= root_in >> 1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/spg_sine_lookup.sv
// Angle to table index and sine table read, two register stages.
`timescale 1ns / 1ps
`default_nettype none

module spg_sine_lookup #(
  parameter int unsigned TABLE_BITS = 10,
  parameter int unsigned IN_W = 25
) (
  input  wire logic               clk,
  input  wire logic [IN_W-1:0]    angle,
  output logic signed [15:0]      sine
);

  localparam int unsigned TABLE_SIZE = 1 << TABLE_BITS;
  localparam int unsigned PROD_W = IN_W + 18;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [15:0] rom_t [TABLE_SIZE];

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] quarter, q, r, x, x2, term, sum, s;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      quarter = 64'(TABLE_SIZE >> 2);
      q = (64'(i) >> (TABLE_BITS - 2)) & 64'd3;
      r = 64'(i) & (quarter - 64'd1);
      if (q[0]) begin
        r = quarter - r;
      end
      x = (HALF_PI_Q30 * r) >> (TABLE_BITS - 2);
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 6; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      s = (sum + 64'd32768) >> 16;
      rom[i] = (q >= 64'd2) ? -16'(s) : 16'(s);
    end
    return rom;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [PROD_W-1:0]     turn;
  logic [TABLE_BITS-1:0] idx;

  assign turn = PROD_W'(angle) * PROD_W'(spg_pkg::TURN_K);

  always_ff @(posedge clk) begin
    idx  <= turn[31 -: TABLE_BITS];
    sine <= ROM[idx];
  end

endmodule

`default_nettype wire

// File: hw/rtl/sine_plasma_pixel_generator_top.sv
// Top level of the sine plasma pixel generator.
//
// A request carries one pixel coordinate and is taken at a rising edge with
// start high; busy stays low, so a new request may come in every cycle.
// A request's result (RGB565 color and framebuffer address) is on result
// for one cycle with done high; one result per cycle sustained. It passes
// the multiply stages, the 16-cell square root chain and the table and
// summing stages. The results cannot be held off; they leave in request order.
// The user must write frame_number over the APB port only between frames,
// while no request is in flight; the block does not enforce this. Reads
// return it. Reset clears frame_number and drops every request in flight.
// pready is always high.
`timescale 1ns / 1ps
`default_nettype none

module sine_plasma_pixel_generator_top #(
  parameter int unsigned SCREEN_WIDTH = 320,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire spg_pkg::pixel_in_t request,
  output logic                    done,
  output spg_pkg::pixel_out_t     result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned LATENCY = 28;
  localparam int unsigned STEPS = spg_pkg::SQRT_STEPS;
  localparam int unsigned AW = spg_pkg::ANGLE_W;
  localparam int unsigned CW = spg_pkg::CH_ANGLE_W;

  logic [31:0] frame_number;
  logic [LATENCY-1:0] vld;

  assign busy = 1'b0;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : frame_number;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_number <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      frame_number <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start && !busy};
    end
  end

  assign done = vld[LATENCY-1];

  logic [39:0] fx_prod, fy_prod;
  logic [31:0] t_prod;
  logic [19:0] addr_full;

  assign fx_prod = 40'({1'b0, request.pixel_x, 10'd0} + 20'd5) * 40'(spg_pkg::RECIP_10);
  assign fy_prod = 40'({2'b0, request.pixel_y, 10'd0} + 20'd5) * 40'(spg_pkg::RECIP_10);
  assign t_prod = 32'(frame_number[23:0]) * 32'(spg_pkg::PHASE_STEP);
  assign addr_full = 20'(request.pixel_y) * 20'(SCREEN_WIDTH) + 20'(request.pixel_x);

  logic [15:0] fx, fy;
  logic [23:0] t1;
  logic [16:0] addr_line [LATENCY];

  always_ff @(posedge clk) begin
    fx <= fx_prod[spg_pkg::RECIP_SHIFT +: 16];
    fy <= fy_prod[spg_pkg::RECIP_SHIFT +: 16];
    t1 <= t_prod[23:0];
    addr_line[0] <= addr_full[16:0];
    for (int i = 1; i < LATENCY; i++) begin
      addr_line[i] <= addr_line[i-1];
    end
  end

  logic [31:0]    fx2, fy2;
  spg_pkg::side_t side2, side3;
  logic [25:0]    mid_sum;
  logic [31:0]    n3;

  assign mid_sum = 26'(fx) + 26'(fy) + 26'(t1);

  always_ff @(posedge clk) begin
    fx2 <= 32'(fx) * 32'(fx);
    fy2 <= 32'(fy) * 32'(fy);
    side2.a0 <= AW'(fx) + AW'(t1);
    side2.a1 <= AW'(fy) + AW'(t1);
    side2.a2 <= mid_sum[25:1];
    side2.t <= t1;
    n3 <= fx2 + fy2;
    side3 <= side2;
  end

  logic [31:0]    rem_c  [STEPS+1];
  logic [31:0]    root_c [STEPS+1];
  spg_pkg::side_t side_c [STEPS+1];

  assign rem_c[0] = n3;
  assign root_c[0] = '0;
  assign side_c[0] = side3;

  for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
    spg_sqrt_cell #(
      .INDEX(k)
    ) u_cell (
      .clk     (clk),
      .rem_in  (rem_c[k]),
      .root_in (root_c[k]),
      .side_in (side_c[k]),
      .rem_out (rem_c[k+1]),
      .root_out(root_c[k+1]),
      .side_out(side_c[k+1])
    );
  end

  logic [AW-1:0] ang [4];

  always_ff @(posedge clk) begin
    ang[0] <= side_c[STEPS].a0;
    ang[1] <= side_c[STEPS].a1;
    ang[2] <= side_c[STEPS].a2;
    ang[3] <= AW'(root_c[STEPS][15:0]) + AW'(side_c[STEPS].t);
  end

  logic signed [15:0] sn [4];

  for (genvar j = 0; j < 4; j++) begin : g_sum_sine
    spg_sine_lookup #(
      .TABLE_BITS(SINE_TABLE_BITS),
      .IN_W      (AW)
    ) u_sine (
      .clk  (clk),
      .angle(ang[j]),
      .sine (sn[j])
    );
  end

  logic signed [18:0] s_sum;
  logic [17:0]        v;
  logic [32:0]        v_prod;
  logic [14:0]        vm;
  logic [CW-1:0]      cang [3];

  assign s_sum = 19'(sn[0]) + 19'(sn[1]) + 19'(sn[2]) + 19'(sn[3]);
  assign v_prod = 33'(v) * 33'(spg_pkg::SCALE_628);

  always_ff @(posedge clk) begin
    v <= 18'(s_sum + 19'(spg_pkg::V_OFFSET));
    vm <= v_prod[31:17];
    cang[0] <= CW'(vm);
    cang[1] <= CW'(vm) + CW'(spg_pkg::PHASE_G);
    cang[2] <= CW'(vm) + CW'(spg_pkg::PHASE_B);
  end

  logic signed [15:0] cs [3];

  for (genvar j = 0; j < 3; j++) begin : g_ch_sine
    spg_sine_lookup #(
      .TABLE_BITS(SINE_TABLE_BITS),
      .IN_W      (CW)
    ) u_sine (
      .clk  (clk),
      .angle(cang[j]),
      .sine (cs[j])
    );
  end

  function automatic logic [7:0] channel(input logic signed [15:0] s);
    logic signed [23:0] p;
    p = 24'(s) * 24'sd127 + 24'(spg_pkg::CH_OFFSET);
    return p[21:14];
  endfunction

  logic [7:0]  ch_r, ch_g, ch_b;
  logic [15:0] color;

  assign ch_r = channel(cs[0]);
  assign ch_g = channel(cs[1]);
  assign ch_b = channel(cs[2]);

  always_ff @(posedge clk) begin
    color <= {ch_r[7:3], ch_g[7:2], ch_b[7:3]};
  end

  assign result = {color, addr_line[LATENCY-1]};

  a_latency : assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("request did not complete after the pipeline latency");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  a_address : assert property (@(posedge clk) disable iff (rst)
    done |-> result.pixel_address == $past(addr_full[16:0], LATENCY))
    else $error("address does not match its request");

endmodule

`default_nettype wire
